@@ hdl/psw_pkg.sv @@
// Shared types and constants for the priority schedule wait-time block.
package psw_pkg;

    localparam int STORE_DEPTH = 16;
    localparam int P_MAX_PROCS = 16;
    localparam int IDX_W       = 4;
    localparam int BURST_W     = 16;
    localparam int PRIO_W      = 8;
    localparam int TIME_W      = 20;
    localparam int SUM_W       = 24;
    localparam int FRAC_W      = 8;
    localparam int AVG_W       = 28;
    localparam int DVD_W       = SUM_W + FRAC_W;

    typedef struct packed {
        logic [BURST_W-1:0] burst_time;
        logic [PRIO_W-1:0]  prio_level;
        logic               last_process;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0]   process_index;
        logic [BURST_W-1:0] burst_out;
        logic [PRIO_W-1:0]  prio_out;
        logic [TIME_W-1:0]  wait_time;
        logic [TIME_W-1:0]  turnaround_time;
        logic [AVG_W-1:0]   avg_wait_q8;
        logic [AVG_W-1:0]   avg_turnaround_q8;
        logic               overflow_flag;
        logic               last_result;
    } t_result;

    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        logic [IDX_W-1:0]   index;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_slot;

    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_EMIT,
        ST_DIV
    } t_state;

endpackage

@@ hdl/psw_cell.sv @@
// One sorting cell: holds one process entry, inserts in priority order, shifts out.
module psw_cell import psw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_new,
    input  t_slot     i_left,
    input  logic      i_left_before,
    input  t_slot     i_right,
    output t_slot     o_slot,
    output logic      o_before
);

    logic   r_valid;
    t_entry r_entry;

    // new entry lands at or ahead of this cell; equal priority stays behind
    assign o_before = !r_valid || (i_new.prio < r_entry.prio);
    assign o_slot   = '{valid: r_valid, entry: r_entry};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_right.valid;
        end else if (i_ctl.ins) begin
            if (i_left_before) begin
                r_valid <= i_left.valid;
            end else if (o_before) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_entry <= i_right.entry;
        end else if (i_ctl.ins) begin
            if (i_left_before) begin
                r_entry <= i_left.entry;
            end else if (o_before) begin
                r_entry <= i_new;
            end
        end
    end

endmodule

@@ hdl/psw_div.sv @@
// Restoring divider, one quotient bit per cycle.
module psw_div import psw_pkg::*; #(
    parameter int DVD_BITS = DVD_W,
    parameter int DVS_BITS = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DVD_BITS-1:0] i_dvd,
    input  logic [DVS_BITS-1:0] i_dvs,
    output logic                o_done,
    output logic [DVD_BITS-1:0] o_quot
);

    localparam int CNT_W = $clog2(DVD_BITS);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [DVD_BITS-1:0] r_quo;
    logic [DVS_BITS-1:0] r_rem;
    logic [DVS_BITS-1:0] r_dvs;
    logic [DVS_BITS:0]   w_trial;
    logic [DVS_BITS:0]   w_diff;
    logic                w_ge;

    always_comb begin
        w_trial = {r_rem, r_quo[DVD_BITS-1]};
        w_ge    = w_trial >= {1'b0, r_dvs};
        w_diff  = w_trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dvd;
            r_rem <= '0;
            r_dvs <= i_dvs;
            r_cnt <= CNT_W'(DVD_BITS - 1);
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_BITS-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DVS_BITS-1:0] : w_trial[DVS_BITS-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

@@ hdl/priority_schedule_wait_times.sv @@
// Processes load one per cycle into a sorted chain of cells; busy stays low while loading.
// The item marked last closes the set: the chain then shifts out one process per cycle in
// ascending priority (ties in arrival order), and results arrive on o_strobe without any
// hold-off, so the receiver must take each one in its cycle. All results but the last come
// out during the shift phase; the last waits for the two averages from the bit-serial
// dividers, and busy stays high after a set's last item and drops as that final result
// appears. Items beyond capacity (MAX_PROCS, at most 16) are dropped and flagged.
module priority_schedule_wait_times import psw_pkg::*; #(
    parameter int MAX_PROCS = P_MAX_PROCS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int CAP   = (MAX_PROCS < STORE_DEPTH) ? MAX_PROCS : STORE_DEPTH;
    localparam int CNT_W = $clog2(CAP + 1);

    t_state    r_state, n_state;
    t_cell_ctl w_ctl;
    logic      w_accept, w_store, w_div_go, w_emit_last;
    logic      w_done_w, w_done_t;

    logic [CNT_W-1:0]  r_count, r_left, r_n, w_n_after;
    logic              r_ovf;
    logic [TIME_W-1:0] r_wait, w_tat;
    logic [SUM_W-1:0]  r_sum_w, r_sum_t, w_sum_w, w_sum_t;
    logic [DVD_W-1:0]  w_quo_w, w_quo_t;
    t_entry            w_new;
    t_result           r_result, r_hold, w_cur, w_fin;
    logic              r_strobe;

    t_slot w_slot   [CAP];
    logic  w_before [CAP];

    assign busy     = (r_state != ST_LOAD);
    assign w_accept = start && !busy;
    assign w_store  = w_accept && (r_count < CNT_W'(CAP));
    assign w_n_after = w_store ? r_count + 1'b1 : r_count;
    assign w_new    = '{burst: i_cmd.burst_time, prio: i_cmd.prio_level,
                        index: IDX_W'(r_count)};

    // sorting chain
    for (genvar k = 0; k < CAP; k++) begin : g_cell
        t_slot w_left, w_right;
        logic  w_left_before;
        if (k == 0) begin : g_head
            assign w_left        = '0;
            assign w_left_before = 1'b0;
        end else begin : g_mid
            assign w_left        = w_slot[k-1];
            assign w_left_before = w_before[k-1];
        end
        if (k == CAP - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_slot[k+1];
        end
        psw_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_new        (w_new),
            .i_left       (w_left),
            .i_left_before(w_left_before),
            .i_right      (w_right),
            .o_slot       (w_slot[k]),
            .o_before     (w_before[k])
        );
    end

    // head cell result and running sums
    always_comb begin
        w_tat = r_wait + TIME_W'(w_slot[0].entry.burst);
        w_sum_w = r_sum_w + SUM_W'(r_wait);
        w_sum_t = r_sum_t + SUM_W'(w_tat);
        w_cur = '{process_index:     w_slot[0].entry.index,
                  burst_out:         w_slot[0].entry.burst,
                  prio_out:          w_slot[0].entry.prio,
                  wait_time:         r_wait,
                  turnaround_time:   w_tat,
                  avg_wait_q8:       '0,
                  avg_turnaround_q8: '0,
                  overflow_flag:     r_ovf,
                  last_result:       1'b0};
    end

    // final beat: held result plus the two averages
    always_comb begin
        w_fin                   = r_hold;
        w_fin.avg_wait_q8       = w_quo_w[AVG_W-1:0];
        w_fin.avg_turnaround_q8 = w_quo_t[AVG_W-1:0];
        w_fin.last_result       = 1'b1;
    end

    psw_div #(.DVD_BITS(DVD_W), .DVS_BITS(CNT_W)) u_div_wait (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_go),
        .i_dvd  ({w_sum_w, {FRAC_W{1'b0}}}),
        .i_dvs  (r_n),
        .o_done (w_done_w),
        .o_quot (w_quo_w)
    );

    psw_div #(.DVD_BITS(DVD_W), .DVS_BITS(CNT_W)) u_div_tat (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_go),
        .i_dvd  ({w_sum_t, {FRAC_W{1'b0}}}),
        .i_dvs  (r_n),
        .o_done (w_done_t),
        .o_quot (w_quo_t)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_ctl       = '0;
        w_div_go    = 1'b0;
        w_emit_last = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                w_ctl.ins = w_store;
                if (w_accept && i_cmd.last_process) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                w_ctl.shift = 1'b1;
                if (r_left == CNT_W'(1)) begin
                    w_emit_last = 1'b1;
                    w_div_go    = 1'b1;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_done_w && w_done_t) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_LOAD: begin
                    if (w_accept) begin
                        if (!w_store) begin
                            r_ovf <= 1'b1;
                        end
                        // close the set: count starts over for the next one
                        r_count <= i_cmd.last_process ? '0 : w_n_after;
                    end
                end
                ST_EMIT: begin
                    r_strobe <= !w_emit_last;
                end
                ST_DIV: begin
                    if (w_done_w && w_done_t) begin
                        r_strobe <= 1'b1;
                        r_ovf    <= 1'b0;
                    end
                end
                default: r_strobe <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_LOAD: begin
                if (w_accept && i_cmd.last_process) begin
                    r_n     <= w_n_after;
                    r_left  <= w_n_after;
                    r_wait  <= '0;
                    r_sum_w <= '0;
                    r_sum_t <= '0;
                end
            end
            ST_EMIT: begin
                r_left   <= r_left - 1'b1;
                r_wait   <= w_tat;
                r_sum_w  <= w_sum_w;
                r_sum_t  <= w_sum_t;
                r_result <= w_cur;
                if (w_emit_last) begin
                    r_hold <= w_cur;
                end
            end
            ST_DIV: begin
                if (w_done_w && w_done_t) begin
                    r_result <= w_fin;
                end
            end
            default: r_result <= r_result;
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

@@ hdl/psw_chk.sv @@
// Port-level checker for the priority schedule block, bound to the top level.
module psw_chk import psw_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input t_cmd    i_cmd,
    input logic    busy,
    input logic    o_strobe,
    input t_result o_result
);

    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last_result |-> busy)
        else $error("non-final beat while block idle");

    a_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last_result |->
            o_result.avg_wait_q8 == '0 && o_result.avg_turnaround_q8 == '0)
        else $error("averages set on non-final beat");

    a_tat_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_result.turnaround_time ==
            TIME_W'(o_result.wait_time + TIME_W'(o_result.burst_out)))
        else $error("turnaround differs from wait plus burst");

    a_close_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_cmd.last_process |=> busy)
        else $error("closing item did not start emission");

    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_result |-> !busy)
        else $error("block still busy on final beat");

endmodule

bind priority_schedule_wait_times psw_chk u_psw_chk (.*);
